// ===== src/acs_pkg.sv =====
// package: widths, constants and types of the attitude command saturator
`timescale 1ns / 1ps
`default_nettype none
package acs_pkg;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 14;
    localparam int W   = SAMPLE_WIDTH;
    localparam int TW  = SAMPLE_WIDTH - 1;  // thrust and scale factor width
    localparam int SW  = SAMPLE_WIDTH + 1;  // sum of three magnitudes
    localparam int QW  = SAMPLE_WIDTH;      // quotient bits, one per divider stage
    localparam int PW  = W + TW;            // product width
    localparam int IW  = 2;                 // register index width
    localparam logic [TW-1:0] ONE = TW'(1) << FRACTION_BITS;

    localparam logic [IW-1:0] REG_YAW_LIMIT    = IW'(0);
    localparam logic [IW-1:0] REG_THRUST_LIMIT = IW'(1);

    // one torque component entering a scaling lane
    typedef struct packed {
        logic          valid;
        logic          do_scale;
        logic          neg;
        logic [W-1:0]  mag;
        logic [TW-1:0] k;
        logic [SW-1:0] sum;
    } t_lane_in;
endpackage
`default_nettype wire

// ===== src/acs_if.sv =====
// stream interfaces for command, saturated command and configuration
`timescale 1ns / 1ps
`default_nettype none
interface acs_cmd_if;
    logic                              valid;
    logic                              ready;
    logic signed [acs_pkg::W-1:0]      roll_torque_in;
    logic signed [acs_pkg::W-1:0]      pitch_torque_in;
    logic signed [acs_pkg::W-1:0]      yaw_torque_in;
    logic signed [acs_pkg::W-1:0]      thrust_in;
    modport source (output valid, roll_torque_in, pitch_torque_in, yaw_torque_in, thrust_in,
                    input ready);
    modport sink   (input valid, roll_torque_in, pitch_torque_in, yaw_torque_in, thrust_in,
                    output ready);
endinterface

interface acs_sat_if;
    logic                              valid;
    logic                              ready;
    logic signed [acs_pkg::W-1:0]      roll_torque_out;
    logic signed [acs_pkg::W-1:0]      pitch_torque_out;
    logic signed [acs_pkg::W-1:0]      yaw_torque_out;
    logic        [acs_pkg::TW-1:0]     thrust_out;
    modport source (output valid, roll_torque_out, pitch_torque_out, yaw_torque_out,
                    thrust_out, input ready);
    modport sink   (input valid, roll_torque_out, pitch_torque_out, yaw_torque_out,
                    thrust_out, output ready);
endinterface

interface acs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [acs_pkg::IW-1:0]        index;
    logic [acs_pkg::W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/acs_front.sv =====
// front stage: yaw and thrust clamps, magnitudes, sum and torque budget
`timescale 1ns / 1ps
`default_nettype none
module acs_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [acs_pkg::W-1:0] i_roll,
    input  wire logic signed [acs_pkg::W-1:0] i_pitch,
    input  wire logic signed [acs_pkg::W-1:0] i_yaw,
    input  wire logic signed [acs_pkg::W-1:0] i_thrust,
    input  wire logic signed [acs_pkg::W-1:0] i_yaw_limit,
    input  wire logic [acs_pkg::TW-1:0]       i_thrust_limit,
    output acs_pkg::t_lane_in                 o_lane [3],
    output logic [acs_pkg::TW-1:0]            o_thr
);
    localparam int W  = acs_pkg::W;
    localparam int TW = acs_pkg::TW;
    localparam int SW = acs_pkg::SW;

    logic signed [W:0]   yl, t2;
    logic [TW-1:0]       lim, thr, budget;
    logic signed [W-1:0] t [3];
    logic [W-1:0]        m [3];
    logic [SW-1:0]       sum;
    logic                do_scale;

    acs_pkg::t_lane_in   r_lane [3];
    logic [TW-1:0]       r_thr;

    always_comb begin
        yl = (W+1)'(i_yaw_limit);
        t2 = (W+1)'(i_yaw);
        if (!yl[W]) begin
            if (t2 > yl) t2 = yl;
            if (-t2 > yl) t2 = -yl;
        end
        lim = (i_thrust_limit > acs_pkg::ONE) ? acs_pkg::ONE : i_thrust_limit;
        if (i_thrust[W-1]) thr = '0;
        else if (i_thrust[W-2:0] > lim) thr = lim;
        else thr = i_thrust[W-2:0];
        budget = acs_pkg::ONE - thr;
        t[0] = i_roll;
        t[1] = i_pitch;
        t[2] = t2[W-1:0];
        for (int j = 0; j < 3; j++) begin
            m[j] = t[j][W-1] ? W'(-t[j]) : W'(t[j]);
        end
        sum = SW'(m[0]) + SW'(m[1]) + SW'(m[2]);
        do_scale = sum > SW'(budget);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_lane[j].do_scale <= do_scale;
                r_lane[j].neg      <= t[j][W-1];
                r_lane[j].mag      <= m[j];
                r_lane[j].k        <= budget;
                r_lane[j].sum      <= sum;
            end
            r_thr <= thr;
        end
        for (int j = 0; j < 3; j++) begin
            if (!i_rst_n) r_lane[j].valid <= 1'b0;
            else if (i_en) r_lane[j].valid <= i_valid;
        end
    end

    assign o_lane = r_lane;
    assign o_thr  = r_thr;
endmodule
`default_nettype wire

// ===== src/acs_scale_lane.sv =====
// scaling lane: |c| * k / sum with a restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module acs_scale_lane (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire acs_pkg::t_lane_in      i_lane,
    output logic                        o_valid,
    output logic signed [acs_pkg::W-1:0] o_val
);
    localparam int W  = acs_pkg::W;
    localparam int SW = acs_pkg::SW;
    localparam int QW = acs_pkg::QW;
    localparam int PW = acs_pkg::PW;

    logic [PW-1:0] prod;
    logic [SW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_low  [QW+1];
    logic [QW-1:0] r_q    [QW+1];
    logic [SW-1:0] r_div  [QW+1];
    logic [W-1:0]  r_mag  [QW+1];
    logic          r_neg  [QW+1];
    logic          r_do   [QW+1];
    logic          r_vld  [QW+1];

    logic [SW:0]   trial [QW];
    logic          qbit  [QW];
    logic [SW-1:0] n_rem [QW];
    logic [W-1:0]  mag_q;

    assign prod = PW'(i_lane.mag) * PW'(i_lane.k);

    always_comb begin
        for (int i = 0; i < QW; i++) begin
            trial[i] = {r_rem[i], r_low[i][QW-1]};
            qbit[i]  = trial[i] >= (SW+1)'(r_div[i]);
            n_rem[i] = qbit[i] ? SW'(trial[i] - (SW+1)'(r_div[i])) : SW'(trial[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient fits in QW bits, so the top of the product starts below the divisor
            r_rem[0] <= SW'(prod[PW-1:QW]);
            r_low[0] <= prod[QW-1:0];
            r_q[0]   <= '0;
            r_div[0] <= i_lane.sum;
            r_mag[0] <= i_lane.mag;
            r_neg[0] <= i_lane.neg;
            r_do[0]  <= i_lane.do_scale;
            for (int i = 0; i < QW; i++) begin
                r_rem[i+1] <= n_rem[i];
                r_low[i+1] <= {r_low[i][QW-2:0], 1'b0};
                r_q[i+1]   <= {r_q[i][QW-2:0], qbit[i]};
                r_div[i+1] <= r_div[i];
                r_mag[i+1] <= r_mag[i];
                r_neg[i+1] <= r_neg[i];
                r_do[i+1]  <= r_do[i];
            end
        end
        if (!i_rst_n) begin
            for (int i = 0; i <= QW; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_lane.valid;
            for (int i = 0; i < QW; i++) r_vld[i+1] <= r_vld[i];
        end
    end

    assign mag_q   = r_do[QW] ? W'(r_q[QW]) : r_mag[QW];
    assign o_val   = r_neg[QW] ? W'(-mag_q) : mag_q;
    assign o_valid = r_vld[QW];
endmodule
`default_nettype wire

// ===== src/attitude_command_saturator.sv =====
// top level: attitude command saturator
//
// i_cmd carries one attitude command per transaction (roll, pitch, yaw
// torque and thrust, signed Q2.14); o_sat returns one saturated command per
// transaction in the same order. i_cfg writes yaw_limit (index 0) and
// thrust_limit (index 1); other indexes are ignored. i_cfg is always ready.
// The pipeline is a clamp stage, two passes of three parallel lanes, each a
// multiply stage plus a restoring divider of one stage per quotient bit, with
// a merge stage that recomputes the torque sum between the passes.
// Throughput is one command per cycle; the whole pipeline moves as one, so
// a new command is taken whenever the last stage is empty or being taken.
// When the receiver stalls the pipeline holds and i_cmd.ready drops.
// Reset clears all stage valid bits and sets yaw_limit to -1 (yaw clamp
// off) and thrust_limit to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module attitude_command_saturator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    acs_cmd_if.sink   i_cmd,
    acs_sat_if.source o_sat,
    acs_cfg_if.sink   i_cfg
);
    localparam int W  = acs_pkg::W;
    localparam int TW = acs_pkg::TW;
    localparam int SW = acs_pkg::SW;
    localparam int QW = acs_pkg::QW;

    logic signed [W-1:0] r_yaw_limit;
    logic [TW-1:0]       r_thrust_limit;
    logic                en;

    acs_pkg::t_lane_in   front_lane [3];
    logic [TW-1:0]       front_thr;
    logic                v1 [3];
    logic signed [W-1:0] t1 [3];
    logic                v2 [3];
    logic signed [W-1:0] t2 [3];
    logic [TW-1:0]       r_thr1 [QW+1];
    logic [TW-1:0]       r_thr2 [QW+1];
    logic [TW-1:0]       r_thr_m;
    acs_pkg::t_lane_in   r_mrg [3];
    logic [W-1:0]        m1 [3];
    logic [SW-1:0]       sum1;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_limit    <= -W'(1);
            r_thrust_limit <= acs_pkg::ONE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                acs_pkg::REG_YAW_LIMIT:    r_yaw_limit    <= i_cfg.data;
                acs_pkg::REG_THRUST_LIMIT: r_thrust_limit <= i_cfg.data[TW-1:0];
                default: ;
            endcase
        end
    end

    assign en          = !v2[0] || o_sat.ready;
    assign i_cmd.ready = en;

    acs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_cmd.valid),
        .i_roll         (i_cmd.roll_torque_in),
        .i_pitch        (i_cmd.pitch_torque_in),
        .i_yaw          (i_cmd.yaw_torque_in),
        .i_thrust       (i_cmd.thrust_in),
        .i_yaw_limit    (r_yaw_limit),
        .i_thrust_limit (r_thrust_limit),
        .o_lane         (front_lane),
        .o_thr          (front_thr)
    );

    for (genvar j = 0; j < 3; j++) begin : g_pass1
        acs_scale_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lane  (front_lane[j]),
            .o_valid (v1[j]),
            .o_val   (t1[j])
        );
    end

    // merge: new sum after the budget pass, compared against thrust
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            m1[j] = t1[j][W-1] ? W'(-t1[j]) : W'(t1[j]);
        end
        sum1 = SW'(m1[0]) + SW'(m1[1]) + SW'(m1[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_thr1[0] <= front_thr;
            for (int i = 0; i < QW; i++) r_thr1[i+1] <= r_thr1[i];
            r_thr_m <= r_thr1[QW];
            r_thr2[0] <= r_thr_m;
            for (int i = 0; i < QW; i++) r_thr2[i+1] <= r_thr2[i];
            for (int j = 0; j < 3; j++) begin
                r_mrg[j].do_scale <= sum1 > SW'(r_thr1[QW]);
                r_mrg[j].neg      <= t1[j][W-1];
                r_mrg[j].mag      <= m1[j];
                r_mrg[j].k        <= r_thr1[QW];
                r_mrg[j].sum      <= sum1;
            end
        end
        for (int j = 0; j < 3; j++) begin
            if (!i_rst_n) r_mrg[j].valid <= 1'b0;
            else if (en) r_mrg[j].valid <= v1[j];
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_pass2
        acs_scale_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lane  (r_mrg[j]),
            .o_valid (v2[j]),
            .o_val   (t2[j])
        );
    end

    assign o_sat.valid            = v2[0];
    assign o_sat.roll_torque_out  = t2[0];
    assign o_sat.pitch_torque_out = t2[1];
    assign o_sat.yaw_torque_out   = t2[2];
    assign o_sat.thrust_out       = r_thr2[QW];
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// testbench for the attitude command saturator: random commands checked against a predictor
`timescale 1ns / 1ps
module tb;
    localparam int W            = acs_pkg::W;
    localparam int TW           = acs_pkg::TW;
    localparam int IW           = acs_pkg::IW;
    localparam int SAMPLE_WIDTH = acs_pkg::SAMPLE_WIDTH;
    localparam logic [TW-1:0] ONE              = acs_pkg::ONE;
    localparam logic [IW-1:0] REG_YAW_LIMIT    = acs_pkg::REG_YAW_LIMIT;
    localparam logic [IW-1:0] REG_THRUST_LIMIT = acs_pkg::REG_THRUST_LIMIT;

    typedef struct packed {
        logic signed [W-1:0] roll;
        logic signed [W-1:0] pitch;
        logic signed [W-1:0] yaw;
        logic [TW-1:0]       thrust;
    } t_sat_cmd;

    // predicted saturated commands, oldest first
    class sat_scoreboard;
        t_sat_cmd    pending[$];
        int          mismatches;
        logic signed [W-1:0] yaw_lim;
        logic [TW-1:0]       thr_lim;

        function new();
            mismatches = 0;
            yaw_lim = -1;
            thr_lim = ONE;
        endfunction

        function longint scale_mag(longint c, longint k, longint s);
            longint q;
            q = ((c < 0 ? -c : c) * k) / s;
            return c < 0 ? -q : q;
        endfunction

        function void note_command(logic signed [W-1:0] r, logic signed [W-1:0] p,
                                   logic signed [W-1:0] y, logic signed [W-1:0] th);
            longint t[3];
            longint thr, lim, budget, sum, one;
            t_sat_cmd e;
            one = longint'(ONE);
            t[0] = r; t[1] = p; t[2] = y;
            thr = th;
            if (yaw_lim >= 0) begin
                if (t[2] > yaw_lim) t[2] = yaw_lim;
                if (-t[2] > yaw_lim) t[2] = -longint'(yaw_lim);
            end
            lim = longint'(thr_lim) > one ? one : longint'(thr_lim);
            if (thr < 0) thr = 0;
            if (thr > lim) thr = lim;
            budget = one - thr;
            sum = 0;
            foreach (t[i]) sum += t[i] < 0 ? -t[i] : t[i];
            if (sum > budget) begin
                foreach (t[i]) t[i] = scale_mag(t[i], budget, sum);
                sum = 0;
                foreach (t[i]) sum += t[i] < 0 ? -t[i] : t[i];
            end
            if (sum > thr) begin
                foreach (t[i]) t[i] = scale_mag(t[i], thr, sum);
            end
            e.roll = W'(t[0]);
            e.pitch = W'(t[1]);
            e.yaw = W'(t[2]);
            e.thrust = TW'(thr);
            pending.push_back(e);
        endfunction

        function void check_result(t_sat_cmd got);
            t_sat_cmd e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (e.roll !== got.roll || e.pitch !== got.pitch || e.yaw !== got.yaw
                    || e.thrust !== got.thrust) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp r=%0d p=%0d y=%0d t=%0d got r=%0d p=%0d y=%0d t=%0d",
                             e.roll, e.pitch, e.yaw, e.thrust,
                             got.roll, got.pitch, got.yaw, got.thrust);
            end
        endfunction
    endclass

    localparam int LATENCY = 2 * (SAMPLE_WIDTH + 1) + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    acs_cmd_if cmd ();
    acs_sat_if sat ();
    acs_cfg_if cfg ();

    attitude_command_saturator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd.sink), .o_sat(sat.source),
        .i_cfg(cfg.sink)
    );

    sat_scoreboard sb;
    int  cycles;
    bit  hold_off;
    bit  stall_random;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial begin
        int g;
        sat.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                sat.ready <= 0;
            end else if (stall_random && $urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    sat.ready <= 0;
                    repeat (g) @(negedge i_clk);
                end
                sat.ready <= 1;
            end else begin
                sat.ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sat.valid && sat.ready)
            sb.check_result({sat.roll_torque_out, sat.pitch_torque_out,
                             sat.yaw_torque_out, sat.thrust_out});
    end

    task automatic write_reg(logic [IW-1:0] idx, logic [W-1:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == REG_YAW_LIMIT) sb.yaw_lim = val;
        else if (idx == REG_THRUST_LIMIT) sb.thr_lim = val[TW-1:0];
        @(negedge i_clk);
        cfg.valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic send_command(logic [W-1:0] r, logic [W-1:0] p, logic [W-1:0] y,
                                logic [W-1:0] th, bit gaps);
        int g;
        if (gaps) begin
            g = gap_len();
            if (g > 0) begin
                cmd.valid <= 0;
                repeat (g) @(negedge i_clk);
            end
        end
        cmd.valid <= 1;
        cmd.roll_torque_in <= r;
        cmd.pitch_torque_in <= p;
        cmd.yaw_torque_in <= y;
        cmd.thrust_in <= th;
        do @(posedge i_clk); while (!cmd.ready);
        sb.note_command(r, p, y, th);
        @(negedge i_clk);
    endtask

    task automatic drain();
        cmd.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function logic [W-1:0] rand_torque();
        case ($urandom_range(0, 4))
            0: return W'($urandom);
            1: return W'($urandom_range(0, 12000)) ^ ($urandom_range(0, 1) ? '1 : '0);
            2: return W'($urandom_range(0, 600));
            3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return W'($signed($urandom_range(0, 32767)) - 16384);
        endcase
    endfunction

    function logic [W-1:0] rand_thrust();
        case ($urandom_range(0, 3))
            0: return W'($urandom);
            1: return W'($urandom_range(0, 16384));
            2: return W'($urandom_range(16300, 16500));
            default: return W'($urandom_range(0, 64));
        endcase
    endfunction

    initial begin
        logic [W-1:0] edge_vals[6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000,
                                       16'hc000, 16'h0001};
        logic [W-1:0] yaw_set[5] = '{16'h7fff, 16'h0000, 16'h8000, 16'h0800, 16'hffff};
        logic [W-1:0] thr_set[5] = '{16'h4000, 16'h0000, 16'h7fff, 16'h2000, 16'h4001};
        sb = new();
        hold_off = 0;
        stall_random = 0;
        i_rst_n = 0;
        cmd.valid = 0;
        cmd.roll_torque_in = 0;
        cmd.pitch_torque_in = 0;
        cmd.yaw_torque_in = 0;
        cmd.thrust_in = 0;
        cfg.valid = 0;
        cfg.index = 0;
        cfg.data = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: field extremes, yaw clamp edges, zero budget
        send_command(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 0);
        send_command(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 0);
        send_command(16'h0000, 16'h0000, 16'h0000, 16'h4000, 0);
        send_command(16'h1000, 16'hf000, 16'h0800, 16'h2000, 0);
        send_command(16'h0001, 16'hffff, 16'h0001, 16'h0001, 0);
        drain();
        write_reg(REG_YAW_LIMIT, 16'h0100);
        write_reg(REG_THRUST_LIMIT, 16'h7fff);
        write_reg(IW'(2), 16'h1234);
        write_reg(IW'(3), 16'h0000);
        foreach (edge_vals[i])
            send_command(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[i],
                         edge_vals[(i + 2) % 6], 0);
        send_command(16'h0010, 16'h0010, 16'h8000, 16'h0100, 0);
        drain();
        write_reg(REG_YAW_LIMIT, 16'h0000);
        write_reg(REG_THRUST_LIMIT, 16'h0000);
        send_command(16'h2000, 16'he000, 16'h8000, 16'h3000, 0);
        send_command(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 0);
        drain();

        // random phases across register settings
        stall_random = 1;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_YAW_LIMIT, ph < 5 ? yaw_set[ph] : W'($urandom));
            write_reg(REG_THRUST_LIMIT, ph < 5 ? thr_set[ph] : W'($urandom));
            if (ph == 3) begin
                hold_off = 1;
                fork
                    begin
                        repeat (LATENCY * 3) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 200; n++)
                send_command(rand_torque(), rand_torque(), rand_torque(), rand_thrust(),
                             ph != 3 || n > 120);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
